### hdl/time_ordered_event_queue_assert.svh
// assertion macros for the time-ordered event queue
// used by the top level; expects clk and rst_n in scope
`ifndef TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH

// checked on every rising clock edge outside reset
`define TOEQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("toeq check failed");

// checked on every rising clock edge, reset included
`define TOEQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("toeq check failed");

`endif

### hdl/toeq_pkg.sv
// shared types and codes for the time-ordered event queue
// no dependencies
`timescale 1ns / 1ps

package toeq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]    event_time;
    logic [KIND_W-1:0]    event_kind;
    logic [PAYLOAD_W-1:0] event_payload;
  } entry_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } ctrl_t;

endpackage

### hdl/toeq_if.sv
// valid/ready channel interfaces for the event queue input and result
// depends on toeq_pkg
`timescale 1ns / 1ps

interface toeq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [toeq_pkg::TIME_W-1:0]       event_time;
  logic [toeq_pkg::KIND_W-1:0]       event_kind;
  logic [toeq_pkg::PAYLOAD_W-1:0]    event_payload;

  modport source (output valid, command, event_time, event_kind, event_payload,
                  input ready);
  modport sink   (input valid, command, event_time, event_kind, event_payload,
                  output ready);
endinterface

interface toeq_out_if;
  logic                              valid;
  logic                              ready;
  logic [toeq_pkg::STATUS_W-1:0]     status;
  logic [toeq_pkg::TIME_W-1:0]       out_time;
  logic [toeq_pkg::KIND_W-1:0]       out_kind;
  logic [toeq_pkg::PAYLOAD_W-1:0]    out_payload;
  logic [toeq_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, status, out_time, out_kind, out_payload, occupancy,
                  input ready);
  modport sink   (input valid, status, out_time, out_kind, out_payload, occupancy,
                  output ready);
endinterface

### hdl/time_ordered_event_queue.sv
// time-ordered event queue: a row of QUEUE_DEPTH cells kept in ascending time
// result offered in the cycle after the input beat; one item per cycle while
// out_bus.ready holds, set by the parallel compare and shift along the cell row
// a result waiting in the output register does not stall input if taken that cycle
// synchronous active-low reset empties the queue and the output register;
// cell contents are not cleared, the entry count alone marks them occupied
`timescale 1ns / 1ps
`include "time_ordered_event_queue_assert.svh"

module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  toeq_in_if.sink    in_bus,
  toeq_out_if.source out_bus
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                             out_valid_r;
  logic [toeq_pkg::STATUS_W-1:0]    status_r;
  logic [toeq_pkg::STATUS_W-1:0]    status_nxt;
  toeq_pkg::entry_t                 result_r;
  toeq_pkg::entry_t                 result_nxt;
  logic [CNT_W-1:0]                 occ_r;

  toeq_pkg::ctrl_t  ctrl;
  toeq_pkg::entry_t cell_q    [QUEUE_DEPTH];
  logic             cell_take [QUEUE_DEPTH];

  logic in_beat;
  logic full;
  logic empty;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_beat      = in_bus.valid && in_bus.ready;
  assign full         = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty        = (count_r == '0);

  assign ctrl.ins = in_beat && (in_bus.command == toeq_pkg::CMD_INSERT) && !full;
  assign ctrl.rem = in_beat && (in_bus.command == toeq_pkg::CMD_REMOVE) && !empty;
  assign ctrl.new_entry.event_time    = in_bus.event_time;
  assign ctrl.new_entry.event_kind    = in_bus.event_kind;
  assign ctrl.new_entry.event_payload = in_bus.event_payload;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    toeq_pkg::entry_t left_q;
    logic             left_take;
    toeq_pkg::entry_t right_q;
    logic             occupied;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_q    = ctrl.new_entry;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_q    = cell_q[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_q = cell_q[i];
    end else begin : g_mid
      assign right_q = cell_q[i+1];
    end

    toeq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_q    (left_q),
      .left_take (left_take),
      .right_q   (right_q),
      .occupied  (occupied),
      .q         (cell_q[i]),
      .take      (cell_take[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = toeq_pkg::ST_OK;
    result_nxt = '0;
    if (in_bus.command == toeq_pkg::CMD_INSERT) begin
      if (full) begin
        status_nxt = toeq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = toeq_pkg::ST_EMPTY;
      end else begin
        result_nxt = cell_q[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      status_r <= status_nxt;
      result_r <= result_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = status_r;
  assign out_bus.out_time    = result_r.event_time;
  assign out_bus.out_kind    = result_r.event_kind;
  assign out_bus.out_payload = result_r.event_payload;
  assign out_bus.occupancy   = toeq_pkg::OCC_W'(occ_r);

  // checks

  `TOEQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))

  `TOEQ_ASSERT(a_insert_grows, ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1))

  `TOEQ_ASSERT(a_remove_front, ctrl.rem |=> result_r == $past(cell_q[0]))

  `TOEQ_ASSERT(a_head_sorted, count_r >= CNT_W'(2) |-> cell_q[0].event_time <= cell_q[1].event_time)

  `TOEQ_ASSERT(a_empty_status, out_valid_r && status_r == toeq_pkg::ST_EMPTY |-> count_r == '0)

endmodule

### hdl/toeq_cell.sv
// one slot of the shift-register queue: holds an entry and compares it with
// the incoming time; depends on toeq_pkg
`timescale 1ns / 1ps

module toeq_cell (
  input  logic             clk,
  input  toeq_pkg::ctrl_t  ctrl,
  input  toeq_pkg::entry_t left_q,
  input  logic             left_take,
  input  toeq_pkg::entry_t right_q,
  input  logic             occupied,
  output toeq_pkg::entry_t q,
  output logic             take
);

  toeq_pkg::entry_t entry_r;
  toeq_pkg::entry_t entry_nxt;

  // slot is at or past the insert point
  assign take = !occupied ||
                (entry_r.event_time >= ctrl.new_entry.event_time);
  assign q = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && take) begin
      // first taking slot gets the new entry, the rest move one to the back
      entry_nxt = left_take ? left_q : ctrl.new_entry;
    end else if (ctrl.rem) begin
      entry_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### tb/testbench.sv
// self-checking bench for the time-ordered event queue: directed and random
// insert/remove traffic under varying back-pressure, checked against a sorted mirror
// depends on toeq_pkg, toeq_if and time_ordered_event_queue
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH       = toeq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int          STALL_LIMIT = 2000;
  localparam int          LONG_HOLD   = 80;

  typedef struct packed {
    logic             command;
    toeq_pkg::entry_t ev;
  } event_item_t;

  typedef struct packed {
    logic [toeq_pkg::STATUS_W-1:0]  status;
    logic [toeq_pkg::TIME_W-1:0]    out_time;
    logic [toeq_pkg::KIND_W-1:0]    out_kind;
    logic [toeq_pkg::PAYLOAD_W-1:0] out_payload;
    logic [toeq_pkg::OCC_W-1:0]     occupancy;
  } outcome_t;

  logic clk;
  logic rst_n;

  toeq_in_if  in_bus();
  toeq_out_if out_bus();

  time_ordered_event_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  event_item_t      send_q[$];
  outcome_t         outcome_q[$];
  toeq_pkg::entry_t mirror_q[$];   // entries in front-to-back order, earliest time first

  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;
  int hold_left;
  int errors;
  int idle_cycles;
  int n_ins_ok, n_rem_ok, n_empty, n_full, peak_occ;
  event_item_t nxt;
  event_item_t seen;
  outcome_t    want;
  outcome_t    got;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // sorted insert ahead of equal or later times, remove from the front
  function automatic outcome_t predict_outcome(event_item_t it);
    outcome_t         r;
    toeq_pkg::entry_t head;
    int               slot;
    r = '0;
    if (it.command == toeq_pkg::CMD_INSERT) begin
      if (mirror_q.size() >= DEPTH) begin
        r.status = toeq_pkg::ST_FULL;
        n_full++;
      end else begin
        slot = 0;
        while (slot < mirror_q.size() && mirror_q[slot].event_time < it.ev.event_time)
          slot++;
        mirror_q.insert(slot, it.ev);
        r.status = toeq_pkg::ST_OK;
        n_ins_ok++;
      end
    end else if (mirror_q.size() == 0) begin
      r.status = toeq_pkg::ST_EMPTY;
      n_empty++;
    end else begin
      head          = mirror_q.pop_front();
      r.status      = toeq_pkg::ST_OK;
      r.out_time    = head.event_time;
      r.out_kind    = head.event_kind;
      r.out_payload = head.event_payload;
      n_rem_ok++;
    end
    r.occupancy = toeq_pkg::OCC_W'(mirror_q.size());
    if (mirror_q.size() > peak_occ) peak_occ = mirror_q.size();
    return r;
  endfunction

  function automatic event_item_t make_event(int insert_pct);
    event_item_t it;
    it.command = ($urandom_range(99) < insert_pct) ? toeq_pkg::CMD_INSERT
                                                   : toeq_pkg::CMD_REMOVE;
    case ($urandom_range(9))
      0, 1, 2, 3: it.ev.event_time = $urandom_range(15);  // many equal times
      4:          it.ev.event_time = '0;
      5:          it.ev.event_time = '1;
      default:    it.ev.event_time = $urandom;
    endcase
    it.ev.event_kind    = toeq_pkg::KIND_W'($urandom_range(3));
    it.ev.event_payload = $urandom;
    return it;
  endfunction

  task automatic push_event(logic cmd, logic [toeq_pkg::TIME_W-1:0] t,
                            logic [toeq_pkg::KIND_W-1:0] k,
                            logic [toeq_pkg::PAYLOAD_W-1:0] p);
    event_item_t it;
    it.command          = cmd;
    it.ev.event_time    = t;
    it.ev.event_kind    = k;
    it.ev.event_payload = p;
    send_q.push_back(it);
  endtask

  // hold off until the sender is empty and every result is back
  task automatic wait_drained();
    while (send_q.size() > 0 || in_bus.valid || outcome_q.size() > 0)
      @(posedge clk);
  endtask

  // driver: record the accepted beat, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        seen.command          = in_bus.command;
        seen.ev.event_time    = in_bus.event_time;
        seen.ev.event_kind    = in_bus.event_kind;
        seen.ev.event_payload = in_bus.event_payload;
        outcome_q.push_back(predict_outcome(seen));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = send_q.pop_front();
          in_bus.command       <= nxt.command;
          in_bus.event_time    <= nxt.ev.event_time;
          in_bus.event_kind    <= nxt.ev.event_kind;
          in_bus.event_payload <= nxt.ev.event_payload;
          in_bus.valid         <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat, then decide ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status      = out_bus.status;
        got.out_time    = out_bus.out_time;
        got.out_kind    = out_bus.out_kind;
        got.out_payload = out_bus.out_payload;
        got.occupancy   = out_bus.occupancy;
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: st=%0d t=%h k=%0d p=%h occ=%0d",
                   $time, got.status, got.out_time, got.out_kind, got.out_payload,
                   got.occupancy);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected st=%0d t=%h k=%0d p=%h occ=%0d", $time,
                     want.status, want.out_time, want.out_kind, want.out_payload,
                     want.occupancy);
            $display("%0t:          actual   st=%0d t=%h k=%0d p=%h occ=%0d", $time,
                     got.status, got.out_time, got.out_kind, got.out_payload,
                     got.occupancy);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with work outstanding but no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (send_q.size() == 0 && !in_bus.valid && outcome_q.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.command       = toeq_pkg::CMD_INSERT;
    in_bus.event_time    = '0;
    in_bus.event_kind    = '0;
    in_bus.event_payload = '0;
    out_bus.ready        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    hold_left      = 0;
    errors         = 0;
    idle_cycles    = 0;
    n_ins_ok = 0; n_rem_ok = 0; n_empty = 0; n_full = 0; peak_occ = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: remove on empty with junk in the ignored fields, then extremes
    push_event(toeq_pkg::CMD_REMOVE, '1, 2'd3, '1);
    push_event(toeq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    push_event(toeq_pkg::CMD_INSERT, 32'h0000_0000, 2'd0, 32'h0000_0000);
    push_event(toeq_pkg::CMD_INSERT, 32'h8000_0000, 2'd1, 32'h5555_5555);
    push_event(toeq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 2'd2, 32'hAAAA_AAAA);
    push_event(toeq_pkg::CMD_INSERT, 32'd5, 2'd1, 32'h0000_00A0);
    // same time again: newest goes ahead of the older one
    push_event(toeq_pkg::CMD_INSERT, 32'd5, 2'd2, 32'h0000_00B0);
    push_event(toeq_pkg::CMD_REMOVE, '0, 2'd0, '0);
    push_event(toeq_pkg::CMD_REMOVE, 32'h1234_5678, 2'd1, 32'h9ABC_DEF0);
    push_event(toeq_pkg::CMD_REMOVE, '0, 2'd0, '0);
    // top up to full, then one insert that must be dropped
    repeat (13) push_event(toeq_pkg::CMD_INSERT, $urandom,
                           toeq_pkg::KIND_W'($urandom_range(3)), $urandom);
    push_event(toeq_pkg::CMD_INSERT, 32'd3, 2'd1, 32'hDEAD_0001);
    wait_drained();

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 36 : 0;
      for (int chunk = 0; chunk < 10; chunk++) begin
        // bias swings occupancy between empty and full
        int bias;
        case ($urandom_range(3))
          0: bias = 20;
          1: bias = 50;
          2: bias = 75;
          default: bias = 92;
        endcase
        repeat (15) send_q.push_back(make_event(bias));
        if (ph == 0 && chunk == 1) long_hold_req = 1'b1;  // back up the output
        if (ph == 1 && chunk == 4) wait_drained();         // sender pause
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("ran %0d inserts, %0d removes, %0d empty removes, %0d full inserts",
             n_ins_ok, n_rem_ok, n_empty, n_full);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, DEPTH, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
